@@ hw/rtl/hsv_to_rgb_converter_defines.svh @@
// ----------------------------------------------------------------------------
// HSV to RGB converter assertion macros
// Concurrent checks clocked on clk and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef HSV_TO_RGB_CONVERTER_DEFINES_SVH
`define HSV_TO_RGB_CONVERTER_DEFINES_SVH

// Check that cons holds once a request has crossed the whole pipeline
`define HSV_ASSERT_LATER(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) \
		(ante) |-> ##(HSV_LATENCY) (cons)) else $error("hsv pipeline check failed");

// Check that cons holds in the same cycle as ante
`define HSV_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) \
		(ante) |-> (cons)) else $error("hsv pipeline check failed");

`endif

@@ hw/rtl/hsv_pkg.sv @@
// ----------------------------------------------------------------------------
// HSV to RGB converter package
// Field widths, fixed-point constants, sector codes and stage payload types.
// ----------------------------------------------------------------------------
package hsv_pkg;

	localparam int HUE_W    = 16;
	localparam int LEVEL_W  = 9;
	localparam int CHAN_W   = 8;
	localparam int FRAC_W   = 16;
	localparam int SECTOR_W = 3;
	localparam int FACTOR_W = 25;
	localparam int PROD_W   = 33;

	// 1.0 for saturation and brightness, and the full factor 2^24
	localparam logic [LEVEL_W-1:0]  LEVEL_ONE   = 9'd256;
	localparam logic [FACTOR_W-1:0] FACTOR_FULL = 25'h100_0000;
	localparam logic [FRAC_W:0]     FRAC_ONE    = 17'h1_0000;

	// Request to result latency in cycles
	localparam int HSV_LATENCY = 5;

	// Hue sectors, floor(6 * hue)
	localparam logic [SECTOR_W-1:0] SEC_RED_YELLOW    = 3'd0;
	localparam logic [SECTOR_W-1:0] SEC_YELLOW_GREEN  = 3'd1;
	localparam logic [SECTOR_W-1:0] SEC_GREEN_CYAN    = 3'd2;
	localparam logic [SECTOR_W-1:0] SEC_CYAN_BLUE     = 3'd3;
	localparam logic [SECTOR_W-1:0] SEC_BLUE_MAGENTA  = 3'd4;

	typedef struct packed {
		logic [HUE_W-1:0]   hue;
		logic [LEVEL_W-1:0] saturation;
		logic [LEVEL_W-1:0] brightness;
	} hsv_req_t;

	typedef struct packed {
		logic [CHAN_W-1:0] red;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] blue;
	} rgb_res_t;

	// p, q, t factors with sector and clamped brightness
	typedef struct packed {
		logic [SECTOR_W-1:0] sector;
		logic [FACTOR_W-1:0] np;
		logic [FACTOR_W-1:0] nq;
		logic [FACTOR_W-1:0] nt;
		logic [LEVEL_W-1:0]  bright;
	} hsv_factor_t;

	// Per-channel factors after the sector switch
	typedef struct packed {
		logic [FACTOR_W-1:0] rn;
		logic [FACTOR_W-1:0] gn;
		logic [FACTOR_W-1:0] bn;
		logic [LEVEL_W-1:0]  bright;
	} hsv_chan_t;

endpackage

@@ hw/rtl/hsv_to_rgb_converter.sv @@
// ----------------------------------------------------------------------------
// HSV to RGB converter
// Converts one hue, saturation, brightness pixel to 8-bit red, green, blue.
//
// Requests arrive on request and are taken at a clock edge where start is
// high and busy is low. busy is always low: the pipeline has no stall and
// takes one request every cycle.
// Each result appears on result for one cycle with done high, in request
// order. The receiver cannot hold results off, so none is ever queued.
// Throughput is 1 pixel per cycle, set by the five register stages: hue
// split, factor multiply, sector switch, brightness multiply, scale by 255.
// Reset clears the stage valid bits, dropping any requests in flight; no
// done pulse follows for them.
// ----------------------------------------------------------------------------
`include "hsv_to_rgb_converter_defines.svh"

module hsv_to_rgb_converter (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  hsv_pkg::hsv_req_t request,
	output logic              done,
	output hsv_pkg::rgb_res_t result
);
	import hsv_pkg::*;

	logic        factor_valid;
	hsv_factor_t factors;
	logic        chan_valid;
	hsv_chan_t   chans;

	// Always ready: one request per cycle flows through
	assign busy = 1'b0;

	hsv_factor u_factor (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (start),
		.request   (request),
		.out_valid (factor_valid),
		.factors   (factors)
	);

	hsv_chan_mux u_chan_mux (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (factor_valid),
		.factors   (factors),
		.out_valid (chan_valid),
		.chans     (chans)
	);

	hsv_scale u_scale (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (chan_valid),
		.chans     (chans),
		.out_valid (done),
		.result    (result)
	);

	// Every request yields exactly one result after the pipeline latency
	`HSV_ASSERT_LATER(a_req_gives_done, start && !busy, done)
	`HSV_ASSERT_NOW(a_done_has_req, done, $past(start, HSV_LATENCY))
	// Grey input gives equal channels, black input gives zero
	`HSV_ASSERT_LATER(a_grey_equal, start && request.saturation == 9'd0,
		result.red == result.green && result.green == result.blue)
	`HSV_ASSERT_LATER(a_black_zero, start && request.brightness == 9'd0,
		result.red == 8'd0 && result.green == 8'd0 && result.blue == 8'd0)
	// Full brightness drives the leading channel to 255
	`HSV_ASSERT_LATER(a_full_peak, start && request.brightness >= 9'd256,
		result.red == 8'd255 || result.green == 8'd255 || result.blue == 8'd255)

endmodule

@@ hw/rtl/hsv_factor.sv @@
// ----------------------------------------------------------------------------
// HSV factor stages
// Stage 1 clamps the levels and splits 6*hue into sector and fraction;
// stage 2 multiplies out the p, q and t factors.
// ----------------------------------------------------------------------------
module hsv_factor (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  hsv_pkg::hsv_req_t    request,
	output logic                 out_valid,
	output hsv_pkg::hsv_factor_t factors
);
	import hsv_pkg::*;

	logic [HUE_W+2:0]    hue6;
	logic [LEVEL_W-1:0]  sat_clamp;
	logic [LEVEL_W-1:0]  bright_clamp;

	logic                valid_s1;
	logic [SECTOR_W-1:0] sector_s1;
	logic [FRAC_W-1:0]   frac_s1;
	logic [LEVEL_W-1:0]  sat_s1;
	logic [LEVEL_W-1:0]  bright_s1;

	logic [FRAC_W:0]     frac_inv;
	logic [FACTOR_W-1:0] fs_prod;
	logic [FACTOR_W-1:0] ct_prod;

	logic                valid_s2;
	hsv_factor_t         factors_s2;

	// Form 6*hue as 4*hue + 2*hue, clamp both levels to 1.0
	assign hue6 = {1'b0, request.hue, 2'b00} + {2'b00, request.hue, 1'b0};
	assign sat_clamp = (request.saturation > LEVEL_ONE) ? LEVEL_ONE : request.saturation;
	assign bright_clamp = (request.brightness > LEVEL_ONE) ? LEVEL_ONE : request.brightness;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid) begin
			sector_s1 <= hue6[HUE_W+2:HUE_W];
			frac_s1   <= hue6[FRAC_W-1:0];
			sat_s1    <= sat_clamp;
			bright_s1 <= bright_clamp;
		end
	end

	// Multiply f*s and (1-f)*s; both stay within 2^24
	assign frac_inv = FRAC_ONE - {1'b0, frac_s1};
	assign fs_prod  = {{(FACTOR_W-FRAC_W){1'b0}}, frac_s1}
		* {{(FACTOR_W-LEVEL_W){1'b0}}, sat_s1};
	assign ct_prod  = {{(FACTOR_W-FRAC_W-1){1'b0}}, frac_inv}
		* {{(FACTOR_W-LEVEL_W){1'b0}}, sat_s1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			factors_s2.sector <= sector_s1;
			factors_s2.np     <= {LEVEL_ONE - sat_s1, {FRAC_W{1'b0}}};
			factors_s2.nq     <= FACTOR_FULL - fs_prod;
			factors_s2.nt     <= FACTOR_FULL - ct_prod;
			factors_s2.bright <= bright_s1;
		end
	end

	assign out_valid = valid_s2;
	assign factors   = factors_s2;

endmodule

@@ hw/rtl/hsv_chan_mux.sv @@
// ----------------------------------------------------------------------------
// HSV sector switch stage
// Stage 3 routes v, p, q and t to the red, green and blue factors.
// ----------------------------------------------------------------------------
module hsv_chan_mux (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  hsv_pkg::hsv_factor_t factors,
	output logic                 out_valid,
	output hsv_pkg::hsv_chan_t   chans
);
	import hsv_pkg::*;

	logic      valid_s3;
	hsv_chan_t chans_s3;
	hsv_chan_t chans_mux;

	// Pick each channel by sector; the last sector takes the default arm
	always_comb begin
		chans_mux.bright = factors.bright;
		case (factors.sector)
			SEC_RED_YELLOW: begin
				chans_mux.rn = FACTOR_FULL;
				chans_mux.gn = factors.nt;
				chans_mux.bn = factors.np;
			end
			SEC_YELLOW_GREEN: begin
				chans_mux.rn = factors.nq;
				chans_mux.gn = FACTOR_FULL;
				chans_mux.bn = factors.np;
			end
			SEC_GREEN_CYAN: begin
				chans_mux.rn = factors.np;
				chans_mux.gn = FACTOR_FULL;
				chans_mux.bn = factors.nt;
			end
			SEC_CYAN_BLUE: begin
				chans_mux.rn = factors.np;
				chans_mux.gn = factors.nq;
				chans_mux.bn = FACTOR_FULL;
			end
			SEC_BLUE_MAGENTA: begin
				chans_mux.rn = factors.nt;
				chans_mux.gn = factors.np;
				chans_mux.bn = FACTOR_FULL;
			end
			default: begin
				chans_mux.rn = FACTOR_FULL;
				chans_mux.gn = factors.np;
				chans_mux.bn = factors.nq;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else begin
			valid_s3 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid) begin
			chans_s3 <= chans_mux;
		end
	end

	assign out_valid = valid_s3;
	assign chans     = chans_s3;

endmodule

@@ hw/rtl/hsv_scale.sv @@
// ----------------------------------------------------------------------------
// HSV output scaling stages
// Stage 4 multiplies brightness by each channel factor; stage 5 scales by
// 255 and keeps bits 39:32, truncating once.
// ----------------------------------------------------------------------------
module hsv_scale (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  hsv_pkg::hsv_chan_t chans,
	output logic               out_valid,
	output hsv_pkg::rgb_res_t  result
);
	import hsv_pkg::*;

	localparam int WIDE_W = PROD_W + 8;

	logic [PROD_W-1:0] red_mul;
	logic [PROD_W-1:0] green_mul;
	logic [PROD_W-1:0] blue_mul;

	logic              valid_s4;
	logic [PROD_W-1:0] red_s4;
	logic [PROD_W-1:0] green_s4;
	logic [PROD_W-1:0] blue_s4;

	logic [WIDE_W-1:0] red_x255;
	logic [WIDE_W-1:0] green_x255;
	logic [WIDE_W-1:0] blue_x255;

	logic              valid_s5;
	rgb_res_t          result_s5;

	// Multiply brightness by the channel factors, at most 2^32
	assign red_mul   = {{(PROD_W-LEVEL_W){1'b0}}, chans.bright}
		* {{(PROD_W-FACTOR_W){1'b0}}, chans.rn};
	assign green_mul = {{(PROD_W-LEVEL_W){1'b0}}, chans.bright}
		* {{(PROD_W-FACTOR_W){1'b0}}, chans.gn};
	assign blue_mul  = {{(PROD_W-LEVEL_W){1'b0}}, chans.bright}
		* {{(PROD_W-FACTOR_W){1'b0}}, chans.bn};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else begin
			valid_s4 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid) begin
			red_s4   <= red_mul;
			green_s4 <= green_mul;
			blue_s4  <= blue_mul;
		end
	end

	// Scale by 255 as 256*x - x
	assign red_x255   = {red_s4, 8'd0} - {8'd0, red_s4};
	assign green_x255 = {green_s4, 8'd0} - {8'd0, green_s4};
	assign blue_x255  = {blue_s4, 8'd0} - {8'd0, blue_s4};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5 <= 1'b0;
		end else begin
			valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s4) begin
			result_s5.red   <= red_x255[39:32];
			result_s5.green <= green_x255[39:32];
			result_s5.blue  <= blue_x255[39:32];
		end
	end

	assign out_valid = valid_s5;
	assign result    = result_s5;

endmodule

@@ verif/hsv_to_rgb_converter_tb.sv @@
// ----------------------------------------------------------------------------
// HSV to RGB converter testbench
// Drives pixel requests through the converter: a directed table of extremes,
// clamped levels and sector edges, then random pixels with random idle
// gaps on the request side. Every done pulse is checked field by field,
// in order, against typed-in results or a fixed-point conversion predictor.
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter_tb;

	timeunit 1ns;
	timeprecision 1ps;

	import hsv_pkg::*;

	localparam int RANDOM_PIXELS = 550;
	localparam int DRAIN_LIMIT   = 2000;

	typedef struct {
		hsv_req_t px;
		bit       typed;
		rgb_res_t want;
	} pixel_row_t;

	logic     clk;
	logic     arst_n;
	logic     start;
	logic     busy;
	hsv_req_t request;
	logic     done;
	rgb_res_t result;

	// expectation travelling with the request on the pins
	rgb_res_t   staged_rgb;
	rgb_res_t   pending_rgb[$];
	pixel_row_t pixel_rows[$];
	int         error_count;
	bit         no_idle;

	hsv_to_rgb_converter dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.request(request),
		.done   (done),
		.result (result)
	);

	always #5 clk = ~clk;

	// Scale one factor by brightness and 255, keep the integer part
	function automatic logic [CHAN_W-1:0] scale_channel(logic [LEVEL_W-1:0] lvl,
			logic [FACTOR_W-1:0] factor);
		logic [63:0] prod;
		prod = 64'd255 * 64'(lvl) * 64'(factor);
		return prod[39:32];
	endfunction

	// Expected red, green, blue for one pixel
	function automatic rgb_res_t hsv_to_rgb_predict(hsv_req_t px);
		logic [LEVEL_W-1:0]  sat;
		logic [LEVEL_W-1:0]  lvl;
		logic [18:0]         hue6;
		logic [SECTOR_W-1:0] sector;
		logic [FRAC_W-1:0]   frac;
		logic [FACTOR_W-1:0] fv;
		logic [FACTOR_W-1:0] fp;
		logic [FACTOR_W-1:0] fq;
		logic [FACTOR_W-1:0] ft;
		logic [FACTOR_W-1:0] fr;
		logic [FACTOR_W-1:0] fg;
		logic [FACTOR_W-1:0] fb;
		rgb_res_t            rgb;
		sat    = (px.saturation > LEVEL_ONE) ? LEVEL_ONE : px.saturation;
		lvl    = (px.brightness > LEVEL_ONE) ? LEVEL_ONE : px.brightness;
		hue6   = 19'(px.hue) * 19'd6;
		sector = hue6[18:16];
		frac   = hue6[15:0];
		fv     = FACTOR_FULL;
		fp     = {LEVEL_ONE - sat, 16'h0000};
		fq     = FACTOR_FULL - 25'(frac) * 25'(sat);
		ft     = FACTOR_FULL - (25'(FRAC_ONE) - 25'(frac)) * 25'(sat);
		case (sector)
			SEC_RED_YELLOW: begin
				fr = fv; fg = ft; fb = fp;
			end
			SEC_YELLOW_GREEN: begin
				fr = fq; fg = fv; fb = fp;
			end
			SEC_GREEN_CYAN: begin
				fr = fp; fg = fv; fb = ft;
			end
			SEC_CYAN_BLUE: begin
				fr = fp; fg = fq; fb = fv;
			end
			SEC_BLUE_MAGENTA: begin
				fr = ft; fg = fp; fb = fv;
			end
			default: begin
				fr = fv; fg = fp; fb = fq;
			end
		endcase
		rgb.red   = scale_channel(lvl, fr);
		rgb.green = scale_channel(lvl, fg);
		rgb.blue  = scale_channel(lvl, fb);
		return rgb;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("mismatch at %0t ns: %s", $realtime, msg);
		error_count++;
	endtask

	// Append one directed row, with or without a typed-in result
	task automatic add_row(input int h, input int s, input int b, input bit typed,
			input int r, input int g, input int bl);
		pixel_row_t row;
		row.px.hue        = h[HUE_W-1:0];
		row.px.saturation = s[LEVEL_W-1:0];
		row.px.brightness = b[LEVEL_W-1:0];
		row.typed         = typed;
		row.want.red      = r[CHAN_W-1:0];
		row.want.green    = g[CHAN_W-1:0];
		row.want.blue     = bl[CHAN_W-1:0];
		pixel_rows.push_back(row);
	endtask

	// Present one request, optionally after an idle gap, and hold it until taken
	task automatic send_pixel(input hsv_req_t px, input rgb_res_t want);
		if (!no_idle && $urandom_range(99) < 6) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		start      <= 1'b1;
		request    <= px;
		staged_rgb <= want;
		do @(posedge clk); while (busy);
	endtask

	// Pick a level: mostly in range, some at the ends, some past 1.0
	function automatic logic [LEVEL_W-1:0] random_level();
		int pick;
		pick = $urandom_range(99);
		if (pick < 15)
			return ($urandom_range(1) != 0) ? LEVEL_ONE : '0;
		else if (pick < 35)
			return LEVEL_W'($urandom);
		else
			return LEVEL_W'($urandom_range(256));
	endfunction

	// Pick a hue: mostly uniform, some close to a sector edge
	function automatic logic [HUE_W-1:0] random_hue();
		int k;
		if ($urandom_range(99) < 25) begin
			k = $urandom_range(6);
			return HUE_W'((k * 65536) / 6 + $urandom_range(4) - 2);
		end
		return HUE_W'($urandom);
	endfunction

	// Queue the expectation on acceptance, check each done pulse in order
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy)
				pending_rgb.push_back(staged_rgb);
			if (done) begin
				if (pending_rgb.size() == 0) begin
					report_mismatch("result with no request waiting");
				end else begin
					rgb_res_t want;
					want = pending_rgb.pop_front();
					if (result.red !== want.red)
						report_mismatch($sformatf("red %0d, want %0d", result.red, want.red));
					if (result.green !== want.green)
						report_mismatch($sformatf("green %0d, want %0d",
							result.green, want.green));
					if (result.blue !== want.blue)
						report_mismatch($sformatf("blue %0d, want %0d",
							result.blue, want.blue));
				end
			end
		end
	end

	// Stop a hung run
	initial begin
		#200_000;
		$display("== FAIL ==");
		$finish;
	end

	initial begin
		hsv_req_t px;
		int       wait_cycles;
		clk         = 1'b0;
		arst_n      = 1'b0;
		start       = 1'b0;
		request     = '0;
		staged_rgb  = '0;
		error_count = 0;
		no_idle     = 1'b0;

		// black, red, cyan, white, gray and clamped levels
		add_row(0,     0,   0,   1, 0,   0,   0);
		add_row(0,     256, 256, 1, 255, 0,   0);
		add_row(32768, 256, 256, 1, 0,   255, 255);
		add_row(0,     0,   256, 1, 255, 255, 255);
		add_row(0,     0,   128, 1, 127, 127, 127);
		add_row(0,     511, 511, 1, 255, 0,   0);
		add_row(32768, 300, 257, 1, 0,   255, 255);
		add_row(0,     0,   511, 1, 255, 255, 255);
		// top of hue, and each side of every sector edge
		add_row(65535, 256, 256, 0, 0, 0, 0);
		add_row(65535, 511, 511, 0, 0, 0, 0);
		add_row(10922, 256, 256, 0, 0, 0, 0);
		add_row(10923, 256, 256, 0, 0, 0, 0);
		add_row(21845, 256, 256, 0, 0, 0, 0);
		add_row(21846, 256, 256, 0, 0, 0, 0);
		add_row(32767, 256, 256, 0, 0, 0, 0);
		add_row(43690, 256, 256, 0, 0, 0, 0);
		add_row(43691, 256, 256, 0, 0, 0, 0);
		add_row(54613, 256, 256, 0, 0, 0, 0);
		add_row(54614, 256, 256, 0, 0, 0, 0);
		add_row(21845, 128, 200, 0, 0, 0, 0);
		add_row(54000, 1,   255, 0, 0, 0, 0);
		add_row(5000,  255, 1,   0, 0, 0, 0);

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// walk the directed table
		foreach (pixel_rows[i])
			send_pixel(pixel_rows[i].px, pixel_rows[i].typed ? pixel_rows[i].want
				: hsv_to_rgb_predict(pixel_rows[i].px));

		// random pixels, with a back-to-back stretch in the middle
		for (int n = 0; n < RANDOM_PIXELS; n++) begin
			no_idle           = (n >= 200 && n < 350);
			px.hue            = random_hue();
			px.saturation     = random_level();
			px.brightness     = random_level();
			send_pixel(px, hsv_to_rgb_predict(px));
		end
		start <= 1'b0;

		// drain the pipeline, then idle further before the final check
		wait_cycles = 0;
		while (pending_rgb.size() != 0 && wait_cycles < DRAIN_LIMIT) begin
			@(posedge clk);
			wait_cycles++;
		end
		repeat (HSV_LATENCY * 4) @(posedge clk);
		if (pending_rgb.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", pending_rgb.size()));

		if (error_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
